FILE: sv/i2cm_pkg.sv
// shared types and constants for the i2c master bit engine
// no dependencies; imported by the front, queue, back and top level
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_CMD   = 2'd0;
  localparam logic [1:0] REQ_WBYTE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // address phase lengths
  localparam int unsigned ADDR7_BITS  = 8;
  localparam int unsigned ADDR10_BITS = 11;

  localparam int unsigned SHIFT_W = 11;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DELAY_W = 16;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_CMD,
    OP_WBYTE,
    OP_TICK,
    OP_NONE
  } op_kind_e;

  // classified item as queued for the sequencer
  typedef struct packed {
    op_kind_e             kind;
    logic [SHIFT_W-1:0]   shift_init;
    logic [3:0]           bit_init;
    logic                 is_read;
    logic                 send_start;
    logic                 send_stop;
    logic [COUNT_W-1:0]   byte_count;
    logic                 scl_level;
    logic                 sda_level;
  } op_t;

  // one result item
  typedef struct packed {
    logic                 scl_pull_low;
    logic                 sda_pull_low;
    logic                 read_valid;
    logic [7:0]           read_data;
    logic                 byte_request;
    logic                 busy;
    logic                 done;
    logic                 start_flag;
    logic                 address_nack_flag;
    logic                 complete_flag;
    logic [COUNT_W-1:0]   bytes_moved;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/i2cm_front.sv
// front end: classifies incoming items and prepares the shift word
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
  input  logic [1:0]            req_type_i,
  input  logic [9:0]            target_address_i,
  input  logic                  ten_bit_mode_i,
  input  logic                  is_read_i,
  input  logic                  send_start_i,
  input  logic                  send_stop_i,
  input  logic [15:0]           byte_count_i,
  input  logic [7:0]            write_byte_i,
  input  logic                  scl_level_i,
  input  logic                  sda_level_i,
  output i2cm_pkg::op_t         op_o
);
  import i2cm_pkg::*;

  // decode the request type and build the word to shift out
  always_comb begin
    op_o            = '0;
    op_o.is_read    = is_read_i;
    op_o.send_start = send_start_i;
    op_o.send_stop  = send_stop_i;
    op_o.byte_count = byte_count_i;
    op_o.scl_level  = scl_level_i;
    op_o.sda_level  = sda_level_i;
    unique case (req_type_i)
      REQ_CMD: begin
        op_o.kind       = OP_CMD;
        op_o.shift_init = {target_address_i, is_read_i};
        op_o.bit_init   = ten_bit_mode_i ? 4'(ADDR10_BITS) : 4'(ADDR7_BITS);
      end
      REQ_WBYTE: begin
        op_o.kind       = OP_WBYTE;
        op_o.shift_init = {3'b000, write_byte_i};
        op_o.bit_init   = 4'(ADDR7_BITS);
      end
      REQ_TICK: begin
        op_o.kind = OP_TICK;
      end
      default: begin
        op_o.kind = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/i2cm_queue.sv
// short queue of classified items between front and back
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_queue #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  i2cm_pkg::op_t         push_op_i,
  output logic                  full_o,
  output logic                  pop_valid_o,
  input  logic                  pop_i,
  output i2cm_pkg::op_t         pop_op_o,
  output logic [CNT_W-1:0]      count_o
);
  import i2cm_pkg::*;

  op_t              entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o      = (count_q == CNT_W'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_op_o    = entry_q[rd_ptr_q];
  assign count_o     = count_q;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/i2cm_back.sv
// back end: line sequencer with the registered result stage
// depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [i2cm_pkg::DELAY_W-1:0]  phase_delay_i,
  input  logic                          op_valid_i,
  input  i2cm_pkg::op_t                 op_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output i2cm_pkg::result_t             res_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_S_WAIT, PH_S_SDA, PH_O_LOW, PH_O_HIGH, PH_A_LOW, PH_A_HIGH,
    PH_A_SAMPLE, PH_WREQ, PH_R_LOW, PH_R_HIGH, PH_R_NEXT, PH_RA_HIGH,
    PH_RA_END, PH_P_SDA, PH_P_SCL
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [3:0]          bit_q, bit_d;
  logic [SHIFT_W-1:0]  shift_q, shift_d;
  logic [COUNT_W-1:0]  done_cnt_q, done_cnt_d;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic [DELAY_W-1:0]  wait_q, wait_d;
  logic                f_start_q, f_start_d;
  logic                f_nack_q, f_nack_d;
  logic                f_read_q, f_read_d;
  logic                f_stop_q, f_stop_d;
  logic                f_addr_q, f_addr_d;
  logic                scl_low_q, scl_low_d;
  logic                sda_low_q, sda_low_d;
  logic                out_valid_q;
  result_t             res_q, res_d;

  logic                do_data, do_end, done;
  logic                rvalid;
  logic [7:0]          rdata;
  logic [3:0]          bit_idx;
  logic [15:0]         shift_ext;
  logic [COUNT_W:0]    next_cnt;

  // take an item whenever the result stage is free or being emptied
  assign pop_o       = op_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign bit_idx   = bit_q - 4'd1;
  assign shift_ext = {5'b00000, shift_q};
  assign next_cnt  = {1'b0, done_cnt_q} + {{COUNT_W{1'b0}}, 1'b1};

  // next state of the sequencer for the item at the queue head
  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    done_cnt_d = done_cnt_q;
    total_d    = total_q;
    wait_d     = wait_q;
    f_start_d  = f_start_q;
    f_nack_d   = f_nack_q;
    f_read_d   = f_read_q;
    f_stop_d   = f_stop_q;
    f_addr_d   = f_addr_q;
    scl_low_d  = scl_low_q;
    sda_low_d  = sda_low_q;
    do_data    = 1'b0;
    do_end     = 1'b0;
    done       = 1'b0;
    rvalid     = 1'b0;
    rdata      = 8'h00;

    if (op_i.kind == OP_CMD && phase_q == PH_IDLE) begin
      f_start_d  = 1'b0;
      f_nack_d   = 1'b0;
      f_addr_d   = 1'b0;
      f_read_d   = op_i.is_read;
      f_stop_d   = op_i.send_stop;
      total_d    = op_i.byte_count;
      done_cnt_d = '0;
      if (op_i.send_start) begin
        f_start_d = 1'b1;
        f_addr_d  = 1'b1;
        shift_d   = op_i.shift_init;
        bit_d     = op_i.bit_init;
        phase_d   = PH_S_WAIT;
        wait_d    = '0;
      end else begin
        do_data = 1'b1;
      end
    end else if (op_i.kind == OP_WBYTE && phase_q == PH_WREQ) begin
      shift_d = op_i.shift_init;
      bit_d   = op_i.bit_init;
      phase_d = PH_O_LOW;
      wait_d  = '0;
    end else if (op_i.kind == OP_TICK && phase_q != PH_IDLE) begin
      if (wait_q != '0) begin
        // delay point still counting down
        wait_d = wait_q - DELAY_W'(1);
      end else begin
        unique case (phase_q)
          PH_S_WAIT: begin
            scl_low_d = 1'b0;
            if (op_i.scl_level) begin
              phase_d = PH_S_SDA;
              wait_d  = phase_delay_i;
            end
          end
          PH_S_SDA: begin
            sda_low_d = 1'b1;
            phase_d   = PH_O_LOW;
            wait_d    = phase_delay_i;
          end
          PH_O_LOW: begin
            scl_low_d = 1'b1;
            sda_low_d = !shift_ext[bit_idx];
            phase_d   = PH_O_HIGH;
            wait_d    = phase_delay_i;
          end
          PH_O_HIGH: begin
            scl_low_d = 1'b0;
            if (op_i.scl_level) begin
              bit_d   = bit_idx;
              phase_d = (bit_idx != 4'd0) ? PH_O_LOW : PH_A_LOW;
              wait_d  = phase_delay_i;
            end
          end
          PH_A_LOW: begin
            scl_low_d = 1'b1;
            sda_low_d = 1'b0;
            phase_d   = PH_A_HIGH;
            wait_d    = phase_delay_i;
          end
          PH_A_HIGH: begin
            scl_low_d = 1'b0;
            if (op_i.scl_level) begin
              phase_d = PH_A_SAMPLE;
              wait_d  = phase_delay_i;
            end
          end
          PH_A_SAMPLE: begin
            scl_low_d = 1'b1;
            if (f_addr_q) begin
              f_addr_d = 1'b0;
              if (op_i.sda_level) begin
                f_nack_d = 1'b1;
                do_end   = 1'b1;
              end else begin
                do_data = 1'b1;
              end
            end else begin
              done_cnt_d = next_cnt[COUNT_W-1:0];
              if (op_i.sda_level) begin
                do_end = 1'b1;
              end else begin
                do_data = 1'b1;
              end
            end
          end
          PH_R_LOW: begin
            scl_low_d = 1'b1;
            sda_low_d = 1'b0;
            phase_d   = PH_R_HIGH;
            wait_d    = phase_delay_i;
          end
          PH_R_HIGH: begin
            scl_low_d = 1'b0;
            if (op_i.scl_level) begin
              shift_d = {shift_q[SHIFT_W-2:0], op_i.sda_level};
              bit_d   = bit_idx;
              phase_d = PH_R_NEXT;
              wait_d  = phase_delay_i;
            end
          end
          PH_R_NEXT: begin
            scl_low_d = 1'b1;
            if (bit_q != 4'd0) begin
              phase_d = PH_R_HIGH;
            end else begin
              // ack every byte but the last
              if (next_cnt < {1'b0, total_q}) begin
                sda_low_d = 1'b1;
              end
              phase_d = PH_RA_HIGH;
            end
            wait_d = phase_delay_i;
          end
          PH_RA_HIGH: begin
            scl_low_d = 1'b0;
            if (op_i.scl_level) begin
              phase_d = PH_RA_END;
              wait_d  = phase_delay_i;
            end
          end
          PH_RA_END: begin
            scl_low_d  = 1'b1;
            rvalid     = 1'b1;
            rdata      = shift_q[7:0];
            done_cnt_d = next_cnt[COUNT_W-1:0];
            do_data    = 1'b1;
          end
          PH_P_SDA: begin
            sda_low_d = 1'b1;
            phase_d   = PH_P_SCL;
            wait_d    = phase_delay_i;
          end
          PH_P_SCL: begin
            scl_low_d = 1'b0;
            if (op_i.scl_level) begin
              sda_low_d = 1'b0;
              phase_d   = PH_IDLE;
              wait_d    = '0;
              done      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // start of the data stage: next byte or wrap-up
    if (do_data) begin
      if (done_cnt_d >= total_d) begin
        do_end = 1'b1;
      end else begin
        wait_d = '0;
        if (f_read_d) begin
          bit_d   = 4'(ADDR7_BITS);
          shift_d = '0;
          phase_d = PH_R_LOW;
        end else begin
          phase_d = PH_WREQ;
        end
      end
    end

    // stop condition or immediate end of the transaction
    if (do_end) begin
      wait_d = '0;
      if (f_stop_d) begin
        phase_d = PH_P_SDA;
      end else begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end
    end

    res_d.scl_pull_low      = scl_low_d;
    res_d.sda_pull_low      = sda_low_d;
    res_d.read_valid        = rvalid;
    res_d.read_data         = rdata;
    res_d.byte_request      = (phase_d == PH_WREQ);
    res_d.busy              = (phase_d != PH_IDLE);
    res_d.done              = done;
    res_d.start_flag        = f_start_d;
    res_d.address_nack_flag = f_nack_d;
    res_d.complete_flag     = done && !f_nack_d;
    res_d.bytes_moved       = done_cnt_d;
  end

  // sequencer state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      done_cnt_q  <= '0;
      total_q     <= '0;
      wait_q      <= '0;
      f_start_q   <= 1'b0;
      f_nack_q    <= 1'b0;
      f_read_q    <= 1'b0;
      f_stop_q    <= 1'b0;
      f_addr_q    <= 1'b0;
      scl_low_q   <= 1'b0;
      sda_low_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q    <= phase_d;
        bit_q      <= bit_d;
        shift_q    <= shift_d;
        done_cnt_q <= done_cnt_d;
        total_q    <= total_d;
        wait_q     <= wait_d;
        f_start_q  <= f_start_d;
        f_nack_q   <= f_nack_d;
        f_read_q   <= f_read_d;
        f_stop_q   <= f_stop_d;
        f_addr_q   <= f_addr_d;
        scl_low_q  <= scl_low_d;
        sda_low_q  <= sda_low_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/i2c_master_bit_engine_core.sv
// top level of the i2c master bit engine: register port, front, queue, back
// depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_back
`timescale 1ns / 1ps
`default_nettype none

// I2C master bit engine. Every input item (command, write byte or bus tick)
// yields exactly one result item. The engine takes one item per clock cycle
// when the result side keeps up: the front decodes an item in the cycle it
// arrives, a small queue (QUEUE_DEPTH entries) holds decoded items, and the
// line sequencer in the back retires one item per cycle into a result
// register. An accepted item is written into the queue and moves into the
// result register once it is at the queue head and that register is free
// or being emptied; items queued ahead and a holding result side delay it.
// Once the queue is full the input stalls until a result is taken.
// phase_delay, register 0 at byte address 0, sets the extra ticks held at
// each delay point and is picked up at the next delay point.

module i2c_master_bit_engine_core #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // register port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input channel
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   req_type_i,
  input  logic [9:0]   target_address_i,
  input  logic         ten_bit_mode_i,
  input  logic         is_read_i,
  input  logic         send_start_i,
  input  logic         send_stop_i,
  input  logic [15:0]  byte_count_i,
  input  logic [7:0]   write_byte_i,
  input  logic         scl_level_i,
  input  logic         sda_level_i,
  // result channel
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         scl_pull_low_o,
  output logic         sda_pull_low_o,
  output logic         read_valid_o,
  output logic [7:0]   read_data_o,
  output logic         byte_request_o,
  output logic         busy_res_o,
  output logic         done_res_o,
  output logic         start_flag_o,
  output logic         address_nack_flag_o,
  output logic         complete_flag_o,
  output logic [15:0]  bytes_moved_o
);
  import i2cm_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic REG_PHASE_DELAY = 1'b0;

  logic [DELAY_W-1:0] phase_delay_q;
  logic               reg_write;
  logic               reg_index;
  op_t                front_op;
  op_t                head_op;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               q_push;
  logic [CNT_W-1:0]   q_count;
  result_t            res;

  // register port
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == REG_PHASE_DELAY) ? {16'h0000, phase_delay_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_delay_q <= '0;
    end else if (reg_write && reg_index == REG_PHASE_DELAY) begin
      phase_delay_q <= pwdata[DELAY_W-1:0];
    end
  end

  // front end classification
  i2cm_front u_front (
    .req_type_i       (req_type_i),
    .target_address_i (target_address_i),
    .ten_bit_mode_i   (ten_bit_mode_i),
    .is_read_i        (is_read_i),
    .send_start_i     (send_start_i),
    .send_stop_i      (send_stop_i),
    .byte_count_i     (byte_count_i),
    .write_byte_i     (write_byte_i),
    .scl_level_i      (scl_level_i),
    .sda_level_i      (sda_level_i),
    .op_o             (front_op)
  );

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && in_ready_o;

  // decoupling queue
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_op_i   (front_op),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_op_o    (head_op),
    .count_o     (q_count)
  );

  // line sequencer and result register
  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_delay_i (phase_delay_q),
    .op_valid_i    (q_valid),
    .op_i          (head_op),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign scl_pull_low_o      = res.scl_pull_low;
  assign sda_pull_low_o      = res.sda_pull_low;
  assign read_valid_o        = res.read_valid;
  assign read_data_o         = res.read_data;
  assign byte_request_o      = res.byte_request;
  assign busy_res_o          = res.busy;
  assign done_res_o          = res.done;
  assign start_flag_o        = res.start_flag;
  assign address_nack_flag_o = res.address_nack_flag;
  assign complete_flag_o     = res.complete_flag;
  assign bytes_moved_o       = res.bytes_moved;

  // a push with no pop grows the queue by one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_count == $past(q_count) + CNT_W'(1)))
    else $error("queue count did not follow a push");

  // a transaction end leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (!busy_res_o && !byte_request_o))
    else $error("done result while still busy");

  // completion is only reported with the end of a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && complete_flag_o) |-> (done_res_o && !address_nack_flag_o))
    else $error("complete flag without clean end");

  // a received byte only arrives during a read data stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_valid_o) |-> (!byte_request_o && !address_nack_flag_o))
    else $error("read byte outside a read data stage");

endmodule

`default_nettype wire
